// ----- rtl/core/qtrs_pkg.sv -----
`default_nettype none
package qtrs_pkg;
  localparam int QW    = 31;  // quotient bits, Q2.30 magnitude up to 1.0
  localparam int NW    = 33;  // norm width, up to 16.0 in unsigned Q5.28
  localparam int LANES = 9;

  typedef logic [NW-1:0] den_t;
  typedef logic [QW-1:0] quo_t;

  // payload that rides alongside the divider
  typedef struct packed {
    logic                  zero;
    logic [LANES-1:0]      neg;
    logic [2:0][31:0]      scale;
    logic [2:0][31:0]      pos;
  } side_t;
endpackage
`default_nettype wire

// ----- rtl/core/quaternion_trs_model_matrix.sv -----
`default_nettype none
// Affine model matrix (translate * rotate * scale) from a Q16.16 position, a
// Q1.14 quaternion and a Q16.16 per-axis scale. One transaction is accepted
// on every clock (busy is tied low) and its matrix appears on done_o in order;
// the receiver cannot stall, so results must be captured in the cycle done_o
// is high. A 31-stage bit-per-stage divider normalizes each rotation element
// to Q2.30; three stages go before it (quaternion products, norm/numerator
// sums, divider setup), the scale multiply and the round/saturate stage
// after it. A zero quaternion yields the identity rotation. Matrix elements
// round to nearest, ties away from zero, and saturate to the Q16.16 range.
// The translation column is the position.
module quaternion_trs_model_matrix
  import qtrs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [31:0] scale_x_i,
  input  wire logic signed [31:0] scale_y_i,
  input  wire logic signed [31:0] scale_z_i,
  output logic                    done_o,
  output logic signed [31:0]      m_r0_c0_o,
  output logic signed [31:0]      m_r0_c1_o,
  output logic signed [31:0]      m_r0_c2_o,
  output logic signed [31:0]      m_r1_c0_o,
  output logic signed [31:0]      m_r1_c1_o,
  output logic signed [31:0]      m_r1_c2_o,
  output logic signed [31:0]      m_r2_c0_o,
  output logic signed [31:0]      m_r2_c1_o,
  output logic signed [31:0]      m_r2_c2_o,
  output logic signed [31:0]      trans_x_o,
  output logic signed [31:0]      trans_y_o,
  output logic signed [31:0]      trans_z_o
);
  // never stalls: fully pipelined
  assign busy = 1'b0;

  // ---- stage 1: quaternion products ----
  logic                v1_q;
  logic signed [31:0]  ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic [2:0][31:0]    sc1_q, pos1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    ww_q   <= quat_w_i * quat_w_i;
    xx_q   <= quat_x_i * quat_x_i;
    yy_q   <= quat_y_i * quat_y_i;
    zz_q   <= quat_z_i * quat_z_i;
    xy_q   <= quat_x_i * quat_y_i;
    wz_q   <= quat_w_i * quat_z_i;
    xz_q   <= quat_x_i * quat_z_i;
    wy_q   <= quat_w_i * quat_y_i;
    yz_q   <= quat_y_i * quat_z_i;
    wx_q   <= quat_w_i * quat_x_i;
    sc1_q  <= {scale_z_i, scale_y_i, scale_x_i};
    pos1_q <= {pos_z_i, pos_y_i, pos_x_i};
  end

  // ---- stage 2: norm and numerators ----
  logic signed [34:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
  logic signed [34:0] nsum;
  logic signed [34:0] num_d [LANES];
  logic signed [34:0] num2_q [LANES];
  den_t               n2_q;
  logic               v2_q;
  logic [2:0][31:0]   sc2_q, pos2_q;

  assign e_ww = 35'(ww_q);
  assign e_xx = 35'(xx_q);
  assign e_yy = 35'(yy_q);
  assign e_zz = 35'(zz_q);
  assign e_xy = 35'(xy_q);
  assign e_wz = 35'(wz_q);
  assign e_xz = 35'(xz_q);
  assign e_wy = 35'(wy_q);
  assign e_yz = 35'(yz_q);
  assign e_wx = 35'(wx_q);
  assign nsum = e_ww + e_xx + e_yy + e_zz;

  always_comb begin
    num_d[0] = e_ww + e_xx - e_yy - e_zz;
    num_d[1] = (e_xy - e_wz) <<< 1;
    num_d[2] = (e_xz + e_wy) <<< 1;
    num_d[3] = (e_xy + e_wz) <<< 1;
    num_d[4] = e_ww - e_xx + e_yy - e_zz;
    num_d[5] = (e_yz - e_wx) <<< 1;
    num_d[6] = (e_xz - e_wy) <<< 1;
    num_d[7] = (e_yz + e_wx) <<< 1;
    num_d[8] = e_ww - e_xx - e_yy + e_zz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n2_q   <= nsum[NW-1:0];
    num2_q <= num_d;
    sc2_q  <= sc1_q;
    pos2_q <= pos1_q;
  end

  // ---- stage 3: magnitude, rounding bias, divider setup ----
  logic [LANES-1:0][NW-1:0] rem_d, rem3_q;
  logic [LANES-1:0][QW-1:0] low_d, low3_q;
  logic [LANES-1:0]         neg_d;
  side_t                    side3_q;
  den_t                     n3_q;
  logic                     v3_q;

  always_comb begin
    logic [NW-1:0] mag;
    logic [63:0]   dvd;
    for (int l = 0; l < LANES; l++) begin
      neg_d[l] = num2_q[l][34];
      mag      = neg_d[l] ? NW'(-num2_q[l]) : NW'(num2_q[l]);
      dvd      = (64'(mag) << (QW - 1)) + 64'(n2_q >> 1);
      rem_d[l] = dvd[QW +: NW];
      low_d[l] = dvd[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem3_q        <= rem_d;
    low3_q        <= low_d;
    n3_q          <= n2_q;
    side3_q.zero  <= (n2_q == '0);
    side3_q.neg   <= neg_d;
    side3_q.scale <= sc2_q;
    side3_q.pos   <= pos2_q;
  end

  // ---- divider: 31 stages ----
  logic                     vd;
  logic [LANES-1:0][QW-1:0] quo;
  side_t                    sided;

  qtrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .den_i   (n3_q),
    .rem_i   (rem3_q),
    .low_i   (low3_q),
    .side_i  (side3_q),
    .valid_o (vd),
    .quo_o   (quo),
    .side_o  (sided)
  );

  // ---- stage 4: sign, identity fallback, scale multiply ----
  logic signed [63:0] p_d [LANES];
  logic signed [63:0] p4_q [LANES];
  logic [2:0][31:0]   pos4_q;
  logic               v4_q;

  always_comb begin
    logic signed [31:0] r;
    logic signed [31:0] sc;
    for (int l = 0; l < LANES; l++) begin
      if (sided.zero) begin
        r = (l % 4 == 0) ? 32'sh4000_0000 : 32'sh0;
      end else if (sided.neg[l]) begin
        r = -$signed({1'b0, quo[l]});
      end else begin
        r = $signed({1'b0, quo[l]});
      end
      sc     = $signed(sided.scale[l % 3]);
      p_d[l] = 64'(r) * 64'(sc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_q   <= p_d;
    pos4_q <= sided.pos;
  end

  // ---- stage 5: round half away from zero, saturate ----
  logic signed [31:0] m_d [LANES];
  logic signed [31:0] m5_q [LANES];
  logic [2:0][31:0]   pos5_q;
  logic               v5_q;

  always_comb begin
    logic signed [63:0] sum;
    logic signed [33:0] v;
    for (int l = 0; l < LANES; l++) begin
      // negative values take bias 2^29-1 so the arithmetic shift rounds
      // ties away from zero
      sum = p4_q[l] + (p4_q[l][63] ? 64'sh1FFF_FFFF : 64'sh2000_0000);
      v   = sum[63:30];
      if (v > 34'sh0_7FFF_FFFF) begin
        m_d[l] = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
        m_d[l] = 32'sh8000_0000;
      end else begin
        m_d[l] = v[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m5_q   <= m_d;
    pos5_q <= pos4_q;
  end

  assign done_o    = v5_q;
  assign m_r0_c0_o = m5_q[0];
  assign m_r0_c1_o = m5_q[1];
  assign m_r0_c2_o = m5_q[2];
  assign m_r1_c0_o = m5_q[3];
  assign m_r1_c1_o = m5_q[4];
  assign m_r1_c2_o = m5_q[5];
  assign m_r2_c0_o = m5_q[6];
  assign m_r2_c1_o = m5_q[7];
  assign m_r2_c2_o = m5_q[8];
  assign trans_x_o = pos5_q[0];
  assign trans_y_o = pos5_q[1];
  assign trans_z_o = pos5_q[2];
endmodule
`default_nettype wire

// ----- rtl/core/qtrs_div.sv -----
`default_nettype none
// Nine restoring dividers sharing one divisor, one quotient bit per stage.
module qtrs_div
  import qtrs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire den_t                   den_i,
  input  wire logic [LANES-1:0][NW-1:0] rem_i,
  input  wire logic [LANES-1:0][QW-1:0] low_i,
  input  wire side_t                  side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QW-1:0]    quo_o,
  output side_t                       side_o
);
  logic [LANES-1:0][NW-1:0] rem_a [QW+1];
  logic [LANES-1:0][QW-1:0] low_a [QW+1];
  logic [LANES-1:0][QW-1:0] quo_a [QW+1];
  den_t                     den_a [QW+1];
  side_t                    side_a[QW+1];
  logic                     vld_a [QW+1];

  assign rem_a[0]  = rem_i;
  assign low_a[0]  = low_i;
  assign quo_a[0]  = '0;
  assign den_a[0]  = den_i;
  assign side_a[0] = side_i;
  assign vld_a[0]  = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LANES-1:0][NW-1:0] rem_d;
    logic [LANES-1:0][QW-1:0] low_d;
    logic [LANES-1:0][QW-1:0] quo_d;
    logic                     vld_q;
    logic [LANES-1:0][NW-1:0] rem_q;
    logic [LANES-1:0][QW-1:0] low_q;
    logic [LANES-1:0][QW-1:0] quo_q;
    den_t                     den_q;
    side_t                    side_q;

    always_comb begin
      logic [NW:0] t;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        t  = {rem_a[k][l], low_a[k][l][QW-1]};
        ge = (t >= {1'b0, den_a[k]});
        rem_d[l] = ge ? NW'(t - {1'b0, den_a[k]}) : t[NW-1:0];
        low_d[l] = {low_a[k][l][QW-2:0], 1'b0};
        quo_d[l] = {quo_a[k][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_a[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      low_q  <= low_d;
      quo_q  <= quo_d;
      den_q  <= den_a[k];
      side_q <= side_a[k];
    end

    assign rem_a[k+1]  = rem_q;
    assign low_a[k+1]  = low_q;
    assign quo_a[k+1]  = quo_q;
    assign den_a[k+1]  = den_q;
    assign side_a[k+1] = side_q;
    assign vld_a[k+1]  = vld_q;
  end

  assign valid_o = vld_a[QW];
  assign quo_o   = quo_a[QW];
  assign side_o  = side_a[QW];
endmodule
`default_nettype wire
